### src/rlm_pkg.sv
// Shared constants for the RMS level meter: register map, reset values, level format.
package rlm_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd1;

  // Register reset values
  localparam logic [3:0]  CHANNEL_COUNT_RST    = 4'd2;
  localparam logic [15:0] SMOOTHING_WEIGHT_RST = 16'd19661;

  // Level format (unsigned Q0.16)
  localparam int          LEVEL_W    = 16;
  localparam logic [15:0] LEVEL_MAX  = 16'hFFFF;
  localparam logic [15:0] ROUND_HALF = 16'h8000;

endpackage

### src/rlm_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module rlm_serdiv #(
  parameter int DD_W = 43,
  parameter int DV_W = 13,
  parameter int ST_W = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DD_W-1:0] dividend,  // left-aligned: the top 'steps' bits are used
  input  logic [DV_W-1:0] divisor,
  input  logic [ST_W-1:0] steps,
  output logic            done,
  output logic [DD_W-1:0] quotient   // quotient in the low 'steps' bits
);

  logic [DD_W-1:0] quo;
  logic [DV_W-1:0] rem;
  logic [DV_W-1:0] dsr;
  logic [ST_W-1:0] left;
  logic            busy;

  logic [DV_W:0]   rem_sh;
  logic [DV_W:0]   diff;
  logic            take;

  // one restoring step
  assign rem_sh = {rem, quo[DD_W-1]};
  assign take   = rem_sh >= {1'b0, dsr};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse after the last step
      done <= busy && !start && (left == ST_W'(1));
      if (start) begin
        busy <= 1'b1;
        left <= steps;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        quo  <= {quo[DD_W-2:0], take};
        rem  <= take ? diff[DV_W-1:0] : rem_sh[DV_W-1:0];
        left <= left - 1'b1;
        if (left == ST_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### src/rlm_sermul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
module rlm_sermul #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] product
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   areg;
  logic [W-1:0]   breg;
  logic [2*W-1:0] acc;
  logic [CW-1:0]  left;
  logic           busy;
  logic [W:0]     psum;

  // add the partial product into the upper half, then shift right
  assign psum = {1'b0, acc[2*W-1:W]} + (breg[0] ? {1'b0, areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse after the last step
      done <= busy && !start && (left == CW'(1));
      if (start) begin
        busy <= 1'b1;
        left <= CW'(W);
        areg <= a;
        breg <= b;
        acc  <= '0;
      end else if (busy) begin
        acc  <= {psum, acc[W-1:1]};
        breg <= breg >> 1;
        left <= left - 1'b1;
        if (left == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign product = acc;

endmodule

### src/block_rms_level_meter_core.sv
// Top level of the block RMS level meter with exponential smoothing.
//
//  channel | direction | signals                                   | word
//  --------+-----------+-------------------------------------------+---------------------------
//  s       | in        | s_tvalid s_tready s_tdata s_tlast         | sample; tlast = block end
//  m       | out       | m_tvalid m_tready m_tdata                 | smoothed level
//  cfg     | in        | cfg_valid cfg_ready cfg_index cfg_data    | register index and value
//
//  A frame close below the frame limit runs the serial divider over the frame-sum width,
//  then the serial multiplier over max(SAMPLE_BITS,16) bits. A block end adds the
//  mean-square divide (energy width, 43 steps), the bit-serial square root (17 steps)
//  and the blend multiply (16 steps). One word is in work at a time; s_tready and
//  cfg_ready are high only while idle. Reset is synchronous; it clears the sequencer,
//  accumulators, smoothed level and output valid flag. A result waits in the output register
//  while input words keep coming; only the next block end stalls until that result is taken.
module block_rms_level_meter_core #(
  parameter int MAX_CHANNELS     = 8,
  parameter int MAX_BLOCK_FRAMES = 4096,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
  input  logic                                   s_tlast,   // end_of_block
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [rlm_pkg::LEVEL_W-1:0]            m_tdata,   // level
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rlm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rlm_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int W      = (SB > 16) ? SB : 16;
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W  = (CH_W > 4) ? CH_W : 4;
  localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FS_W   = SB + $clog2(MAX_CHANNELS);
  localparam int FR_W   = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int EN_W   = 2 * SB - 2 + FR_W;
  localparam int DV_W   = (FR_W > CNT_W) ? FR_W : CNT_W;
  localparam int ST_W   = $clog2(EN_W + 1);
  localparam int MS_W   = 2 * SB - 1;
  localparam int SQ_EV  = (SB <= 17) ? 34 : 2 * SB;
  localparam int RT_W   = SQ_EV / 2;
  localparam int SL_W   = $clog2(RT_W + 1);
  localparam int SHL    = (SB <= 17) ? 2 * (17 - SB) : 0;
  localparam int SHR    = (SB > 17) ? SB - 17 : 0;
  localparam int LW     = rlm_pkg::LEVEL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MONO_DIV,
    ST_SQUARE,
    ST_BLOCK,
    ST_MS_DIV,
    ST_SQRT,
    ST_RMS,
    ST_OUT
  } state_t;

  // registers
  state_t                  state;
  logic [3:0]              channel_count;
  logic [15:0]             smoothing_weight;
  logic signed [FS_W-1:0]  frame_sum;
  logic [POS_W-1:0]        channel_position;
  logic [EN_W-1:0]         energy_total;
  logic [FR_W-1:0]         frames_seen;
  logic [LW-1:0]           smoothed_level;
  logic                    last_q;
  logic                    blend_sub;
  logic                    out_valid;
  logic [LW-1:0]           out_level;
  logic                    mul_ready_q;

  logic                    div_start;
  logic [EN_W-1:0]         div_dividend;
  logic [DV_W-1:0]         div_divisor;
  logic [ST_W-1:0]         div_steps;
  logic                    div_done;
  logic [EN_W-1:0]         div_quotient;

  logic                    mul_start;
  logic [W-1:0]            mul_a;
  logic [W-1:0]            mul_b;
  logic                    mul_done;
  logic [2*W-1:0]          mul_product;

  logic [SQ_EV-1:0]        sq_op;
  logic [RT_W:0]           sq_rem;
  logic [RT_W-1:0]         sq_root;
  logic [SL_W-1:0]         sq_left;

  // combinational
  logic [CNT_W-1:0]        count;
  logic signed [FS_W-1:0]  sum;
  logic [FS_W-1:0]         sum_mag;
  logic                    frame_done;
  logic                    accept;
  logic                    div_start_next;
  logic                    mul_start_next;
  logic [RT_W+2:0]         sq_rem_sh;
  logic [RT_W+2:0]         sq_trial;
  logic                    sq_take;
  logic [RT_W+2:0]         sq_diff;
  logic [RT_W-1:0]         root_sh;
  logic [LW-1:0]           rms;
  logic [32:0]             blend_base;
  logic [32:0]             blend_sum;
  logic [LW-1:0]           blend_level;
  logic                    out_free;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_level;
  assign out_free  = !out_valid || m_tready;

  // channel count, saturated to the supported maximum
  assign count = (CNT_W'(channel_count) > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                              : CNT_W'(channel_count);

  // frame accumulation
  assign sum        = frame_sum + FS_W'($signed(s_tdata[SB-1:0]));
  assign sum_mag    = sum[FS_W-1] ? FS_W'(-sum) : FS_W'(sum);
  assign frame_done = s_tlast ||
                      (({1'b0, CNT_W'(channel_position)} + 1'b1) >= {1'b0, count});

  // divider and multiplier launches
  assign div_start_next = (state == ST_BLOCK) ||
                          (accept && (channel_count != 4'd0) && frame_done &&
                           (frames_seen < FR_W'(MAX_BLOCK_FRAMES)));
  assign mul_start_next = ((state == ST_MONO_DIV) && div_done) || (state == ST_RMS);

  // square root step: two radicand bits per cycle
  assign sq_rem_sh = {sq_rem, sq_op[SQ_EV-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root, 2'b01};
  assign sq_take   = sq_rem_sh >= sq_trial;
  assign sq_diff   = sq_rem_sh - sq_trial;

  // scale and saturate the root into Q0.16
  assign root_sh = sq_root >> SHR;
  assign rms     = (|root_sh[RT_W-1:LW]) ? rlm_pkg::LEVEL_MAX : root_sh[LW-1:0];

  // blend: level + w*(rms - level), rounded to nearest
  assign blend_base  = {1'b0, smoothed_level, rlm_pkg::ROUND_HALF};
  assign blend_sum   = blend_sub ? blend_base - {1'b0, mul_product[31:0]}
                                 : blend_base + {1'b0, mul_product[31:0]};
  assign blend_level = blend_sum[31:16];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= rlm_pkg::CHANNEL_COUNT_RST;
      smoothing_weight <= rlm_pkg::SMOOTHING_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rlm_pkg::REG_CHANNEL_COUNT:    channel_count    <= cfg_data[3:0];
        rlm_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_sum        <= '0;
      channel_position <= '0;
      energy_total     <= '0;
      frames_seen      <= '0;
      smoothed_level   <= '0;
      out_valid        <= 1'b0;
      div_start        <= 1'b0;
      mul_start        <= 1'b0;
    end else begin
      div_start <= div_start_next;
      mul_start <= mul_start_next;
      // taken word leaves unless a new level loads in the same cycle
      if (out_valid && m_tready && !((state == ST_OUT) && mul_ready_q)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (channel_count != 4'd0)) begin
            if (!frame_done) begin
              frame_sum        <= sum;
              channel_position <= channel_position + 1'b1;
            end else begin
              frame_sum        <= '0;
              channel_position <= '0;
              last_q           <= s_tlast;
              if (frames_seen < FR_W'(MAX_BLOCK_FRAMES)) begin
                div_dividend <= EN_W'(sum_mag) << (EN_W - FS_W);
                div_divisor  <= DV_W'(count);
                div_steps    <= ST_W'(FS_W);
                state        <= ST_MONO_DIV;
              end else if (s_tlast) begin
                state <= ST_BLOCK;
              end
            end
          end
        end
        ST_MONO_DIV: begin
          if (div_done) begin
            mul_a     <= W'(div_quotient[SB-1:0]);
            mul_b     <= W'(div_quotient[SB-1:0]);
            state     <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mul_done) begin
            energy_total <= energy_total + EN_W'(mul_product[MS_W-1:0]);
            frames_seen  <= frames_seen + 1'b1;
            state        <= last_q ? ST_BLOCK : ST_IDLE;
          end
        end
        ST_BLOCK: begin
          div_dividend <= energy_total;
          div_divisor  <= DV_W'(frames_seen);
          div_steps    <= ST_W'(EN_W);
          energy_total <= '0;
          frames_seen  <= '0;
          state        <= ST_MS_DIV;
        end
        ST_MS_DIV: begin
          if (div_done) begin
            sq_op   <= SQ_EV'(div_quotient[MS_W-1:0]) << SHL;
            sq_rem  <= '0;
            sq_root <= '0;
            sq_left <= SL_W'(RT_W);
            state   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sq_op   <= sq_op << 2;
          sq_rem  <= sq_take ? sq_diff[RT_W:0] : sq_rem_sh[RT_W:0];
          sq_root <= {sq_root[RT_W-2:0], sq_take};
          sq_left <= sq_left - 1'b1;
          if (sq_left == SL_W'(1)) begin
            state <= ST_RMS;
          end
        end
        ST_RMS: begin
          mul_a     <= W'(smoothing_weight);
          blend_sub <= rms < smoothed_level;
          mul_b     <= (rms < smoothed_level) ? W'(smoothed_level - rms)
                                              : W'(rms - smoothed_level);
          state     <= ST_OUT;
        end
        ST_OUT: begin
          // waits for the blend product and for a free output register
          if (mul_ready_q && out_free) begin
            out_valid      <= 1'b1;
            out_level      <= blend_level;
            smoothed_level <= blend_level;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // product of the blend multiply is valid from its done pulse until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_ready_q <= 1'b0;
    end else if (mul_start) begin
      mul_ready_q <= 1'b0;
    end else if (mul_done && (state == ST_OUT)) begin
      mul_ready_q <= 1'b1;
    end
  end

  rlm_serdiv #(
    .DD_W (EN_W),
    .DV_W (DV_W),
    .ST_W (ST_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quotient)
  );

  rlm_sermul #(
    .W (W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // checks
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MONO_DIV || state == ST_MS_DIV))
    else $error("divider finished outside a divide step");

  a_mul_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_SQUARE || state == ST_OUT))
    else $error("multiplier finished outside a multiply step");

  a_frames_bounded: assert property (@(posedge clk) disable iff (rst)
    frames_seen <= FR_W'(MAX_BLOCK_FRAMES))
    else $error("frame counter passed its limit");

  a_block_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MS_DIV) |-> (energy_total == '0 && frames_seen == '0))
    else $error("accumulators not cleared at block end");

endmodule
